FILE: src/pilot_duty_decoder_assert.svh
// Assertion macros for the pilot duty decoder RTL.
`ifndef PILOT_DUTY_DECODER_ASSERT_SVH
`define PILOT_DUTY_DECODER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pdd_pkg.sv
// Package for the pilot duty decoder: widths, constants, codes and control types.
`default_nettype none
package pdd_pkg;

  // Counter width and derived limits
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int DUTY_W  = 7;
  localparam int SUM_W   = COUNT_BITS + 1;
  localparam int DIV_W   = COUNT_BITS + DUTY_W;
  localparam int STEP_W  = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DUTY_W - 1);

  // Field widths
  localparam int MV_W    = 12;
  localparam int CUR_W   = 10;
  localparam int CLASS_W = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP       = 2'd1;
  localparam logic [MV_W-1:0]  THRESHOLD_RESET = 12'd100;
  localparam logic [CUR_W-1:0] CAP_RESET       = 10'd900;

  // Duty to current mapping
  localparam logic [DUTY_W-1:0] DUTY_LOW_MIN  = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_LOW_MAX  = 7'd85;
  localparam logic [DUTY_W-1:0] DUTY_HIGH_MAX = 7'd100;
  localparam logic [CUR_W-1:0]  LOW_SCALE     = 10'd6;
  localparam logic [CUR_W-1:0]  HIGH_OFFSET   = 10'd64;
  localparam logic [CUR_W-1:0]  HIGH_SCALE    = 10'd25;
  localparam logic [DIV_W-1:0]  PERCENT       = DIV_W'(100);

  // Pilot level class boundaries, mV
  localparam logic [MV_W-1:0] LV_STANDBY_HI = 12'd3300;
  localparam logic [MV_W-1:0] LV_STANDBY_LO = 12'd2750;
  localparam logic [MV_W-1:0] LV_DETECT_LO  = 12'd2200;
  localparam logic [MV_W-1:0] LV_READY_HI   = 12'd1925;
  localparam logic [MV_W-1:0] LV_READY_LO   = 12'd1375;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_STANDBY  = 3'd0,
    CLASS_DETECT   = 3'd1,
    CLASS_READY    = 3'd2,
    CLASS_NO_POWER = 3'd3,
    CLASS_ERROR    = 3'd4
  } pdd_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } pdd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the request, update counts
    logic step;   // one restoring divide step
    logic last;   // final divide step, latch duty
    logic emit;   // load the result register
  } pdd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic edge_found;
    logic out_free;
  } pdd_status_t;

endpackage
`default_nettype wire

FILE: src/pdd_sample_if.sv
// Sample and result channel interfaces of the pilot duty decoder.
`default_nettype none
interface pdd_sample_if;
  logic                        valid;
  logic                        ready;
  logic [pdd_pkg::MV_W-1:0]    pilot_sample_mv;

  modport source (output valid, output pilot_sample_mv, input ready);
  modport sink   (input valid, input pilot_sample_mv, output ready);
endinterface

interface pdd_result_if;
  logic                        valid;
  logic                        ready;
  logic [pdd_pkg::DUTY_W-1:0]  duty_percent;
  logic [pdd_pkg::CUR_W-1:0]   allowed_current_deciamps;
  logic [pdd_pkg::CLASS_W-1:0] pilot_class;
  logic [pdd_pkg::MV_W-1:0]    pilot_level_mv;

  modport source (output valid, output duty_percent, output allowed_current_deciamps,
                  output pilot_class, output pilot_level_mv, input ready);
  modport sink   (input valid, input duty_percent, input allowed_current_deciamps,
                  input pilot_class, input pilot_level_mv, output ready);
endinterface
`default_nettype wire

FILE: src/pdd_ctrl.sv
// Controller state machine: request intake, divide sequencing and result hand-off.
`default_nettype none
module pdd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pdd_pkg::pdd_status_t sts,
  output pdd_pkg::pdd_cmd_t         cmd
);
  import pdd_pkg::*;

  pdd_state_t        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              accept;

  assign accept = in_valid && (state == ST_IDLE);

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        step_cnt_next = '0;
        if (accept) begin
          state_next = sts.edge_found ? ST_DIVIDE : ST_WRITE;
        end
      end
      ST_DIVIDE: begin
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        cmd.last = (step_cnt == LAST_STEP);
      end
      ST_WRITE: begin
        cmd.emit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/pdd_dp.sv
// Datapath: configuration, sample counters, duty divider and result register.
`default_nettype none
module pdd_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pdd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [pdd_pkg::MV_W-1:0]        sample_mv,
  input  wire pdd_pkg::pdd_cmd_t              cmd,
  output pdd_pkg::pdd_status_t                sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pdd_pkg::DUTY_W-1:0]           out_duty,
  output logic [pdd_pkg::CUR_W-1:0]            out_current,
  output logic [pdd_pkg::CLASS_W-1:0]          out_class,
  output logic [pdd_pkg::MV_W-1:0]             out_level
);
  import pdd_pkg::*;

  logic [MV_W-1:0]       threshold;
  logic [CUR_W-1:0]      cap;
  logic [MV_W-1:0]       prev_sample;
  logic [COUNT_BITS-1:0] high_cnt, low_cnt;
  logic [DUTY_W-1:0]     duty;
  logic [MV_W-1:0]       held_level;
  logic [DIV_W-1:0]      rem, div_sh;
  logic [DUTY_W-1:0]     quo;
  logic                  div_zero;

  logic                  edge_found, is_high;
  logic [COUNT_BITS-1:0] high_base, low_base;
  logic [SUM_W-1:0]      total;
  logic                  q_bit;
  logic [CUR_W-1:0]      cur_raw, cur_val;
  pdd_class_t            lv_class;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      cap       <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[MV_W-1:0];
        REG_CAP:       cap       <= cfg_data[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Rising edge: clear jump past threshold from below it
  assign edge_found = (sample_mv > prev_sample)
                   && ((sample_mv - prev_sample) > threshold)
                   && (prev_sample < threshold);
  assign is_high    = sample_mv > threshold;
  assign high_base  = edge_found ? '0 : high_cnt;
  assign low_base   = edge_found ? '0 : low_cnt;
  assign total      = {1'b0, high_cnt} + {1'b0, low_cnt};

  assign sts.edge_found = edge_found;
  assign sts.out_free   = !out_valid || out_ready;

  // Sample history and saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      high_cnt    <= '0;
      low_cnt     <= '0;
      held_level  <= '0;
    end else if (cmd.load) begin
      prev_sample <= sample_mv;
      if (is_high) begin
        held_level <= sample_mv;
        high_cnt   <= (high_base == COUNT_MAX) ? high_base : high_base + 1'b1;
        low_cnt    <= low_base;
      end else begin
        high_cnt   <= high_base;
        low_cnt    <= (low_base == COUNT_MAX) ? low_base : low_base + 1'b1;
      end
    end
  end

  // Restoring divide: high*100 / (high+low), one quotient bit a step
  assign q_bit = rem >= div_sh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem      <= DIV_W'(high_cnt) * PERCENT;
      div_sh   <= {total, (DUTY_W-1)'(0)};
      div_zero <= (total == '0);
      quo      <= '0;
    end else if (cmd.step) begin
      if (q_bit) begin
        rem <= rem - div_sh;
      end
      div_sh <= div_sh >> 1;
      quo    <= {quo[DUTY_W-2:0], q_bit};
    end
  end

  // Latched duty, empty period gives zero
  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= '0;
    end else if (cmd.last) begin
      duty <= div_zero ? '0 : {quo[DUTY_W-2:0], q_bit};
    end
  end

  // Allowed current from duty, then cap
  always_comb begin
    if (duty > DUTY_LOW_MAX && duty <= DUTY_HIGH_MAX) begin
      cur_raw = CUR_W'((CUR_W'(duty) - HIGH_OFFSET) * HIGH_SCALE);
    end else if (duty >= DUTY_LOW_MIN && duty <= DUTY_LOW_MAX) begin
      cur_raw = CUR_W'(CUR_W'(duty) * LOW_SCALE);
    end else begin
      cur_raw = '0;
    end
    cur_val = (cur_raw > cap) ? cap : cur_raw;
  end

  // Pilot class from held level; boundary values fall to error
  always_comb begin
    if (held_level > LV_STANDBY_LO && held_level < LV_STANDBY_HI) begin
      lv_class = CLASS_STANDBY;
    end else if (held_level < LV_STANDBY_LO && held_level > LV_DETECT_LO) begin
      lv_class = CLASS_DETECT;
    end else if (held_level < LV_READY_HI && held_level > LV_READY_LO) begin
      lv_class = CLASS_READY;
    end else if (held_level == '0) begin
      lv_class = CLASS_NO_POWER;
    end else begin
      lv_class = CLASS_ERROR;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_duty    <= duty;
      out_current <= cur_val;
      out_class   <= lv_class;
      out_level   <= held_level;
    end
  end

endmodule
`default_nettype wire

FILE: src/pilot_duty_decoder.sv
// Pilot duty decoder: an edge-timed duty meter for the charging control pilot, one result
// per sample. A sample goes from acceptance through the write state to the result register;
// a sample that marks a rising edge first passes the duty of the period just ended through a
// restoring divider that resolves one quotient bit per cycle. A new sample is taken
// while the previous result still waits in the output register; only a running divide or a
// full output register at the end of a sample holds the next one off.
`default_nettype none
module pilot_duty_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pdd_pkg::CFG_DATA_W-1:0]  cfg_data,
  pdd_sample_if.sink                           sample,
  pdd_result_if.source                         result
);
  import pdd_pkg::*;

  pdd_cmd_t    cmd;
  pdd_status_t sts;

  pdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_mv   (sample.pilot_sample_mv),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_duty    (result.duty_percent),
    .out_current (result.allowed_current_deciamps),
    .out_class   (result.pilot_class),
    .out_level   (result.pilot_level_mv)
  );

  // Checks
  `include "pilot_duty_decoder_assert.svh"

  `PDD_ASSERT(a_edge_starts_divide, (sample.valid && sample.ready && sts.edge_found) |=> cmd.step, "edge request did not start divide")
  `PDD_ASSERT(a_no_take_while_busy, cmd.step |-> !sample.ready, "request taken during divide")
  `PDD_ASSERT(a_emit_gives_result, cmd.emit |=> result.valid, "result not presented after emit")
  `PDD_ASSERT_ALWAYS(a_reset_clears_result, $past(rst) |-> !result.valid, "result valid after reset")

endmodule
`default_nettype wire

FILE: tb/sv/pilot_duty_decoder_tb.sv
// Self-checking testbench for the pilot duty decoder: duty, current, class and level per sample.
`timescale 1ns / 100ps
module pilot_duty_decoder_tb;
  import pdd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_RUN = 14;
  localparam int SHORT_RUN = 6;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 1;
  // Indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic [CUR_W-1:0]  current;
    pdd_class_t        pilot;
    logic [MV_W-1:0]   level;
  } reading_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pdd_sample_if pilot_in();
  pdd_result_if reading_out();

  pilot_duty_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   (pilot_in),
    .result   (reading_out)
  );

  // Decoder state as predicted
  logic [MV_W-1:0]   cfg_threshold = THRESHOLD_RESET;
  logic [CUR_W-1:0]  cfg_cap = CAP_RESET;
  logic [MV_W-1:0]   prev_mv = '0;
  longint unsigned   high_run = 0;
  longint unsigned   low_run = 0;
  logic [DUTY_W-1:0] duty_held = '0;
  logic [MV_W-1:0]   level_held = '0;

  // Stimulus and scoreboard
  logic [MV_W-1:0] sample_queue[$];
  reading_t        expected_readings[$];
  bit              staged = 1'b0;
  int              last_mv = 0;
  int              queued_total = 0;
  int              send_idle_pct = 20;
  int              recv_idle_pct = 51;
  int              samples_taken = 0;
  int              readings_checked = 0;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predict one reading, updating the counts, latched duty and held level
  function automatic reading_t decode_sample(input logic [MV_W-1:0] mv);
    reading_t r;
    longint unsigned total;
    int unsigned amps;
    if (mv > prev_mv && (mv - prev_mv) > cfg_threshold && prev_mv < cfg_threshold) begin
      total = high_run + low_run;
      duty_held = (total == 0) ? '0 : DUTY_W'((high_run * 100) / total);
      high_run = 0;
      low_run = 0;
    end
    if (mv > cfg_threshold) begin
      level_held = mv;
      if (high_run < COUNT_CEIL) high_run++;
    end else if (low_run < COUNT_CEIL) begin
      low_run++;
    end
    prev_mv = mv;

    if (duty_held > 85 && duty_held <= 100) amps = (duty_held - 64) * 25;
    else if (duty_held >= 10 && duty_held <= 85) amps = duty_held * 6;
    else amps = 0;
    if (amps > cfg_cap) amps = cfg_cap;

    // Class windows are open: a level on a boundary is an error
    if (level_held > 2750 && level_held < 3300) r.pilot = CLASS_STANDBY;
    else if (level_held < 2750 && level_held > 2200) r.pilot = CLASS_DETECT;
    else if (level_held < 1925 && level_held > 1375) r.pilot = CLASS_READY;
    else if (level_held == 0) r.pilot = CLASS_NO_POWER;
    else r.pilot = CLASS_ERROR;

    r.duty = duty_held;
    r.current = CUR_W'(amps);
    r.level = level_held;
    return r;
  endfunction

  // High level biased towards the class windows and their boundaries
  function automatic int pick_high_level(input int t);
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(3299, 2751);
      1: v = $urandom_range(2749, 2201);
      2: v = $urandom_range(1924, 1376);
      3: begin
        case ($urandom_range(4))
          0: v = 1375;
          1: v = 1925;
          2: v = 2200;
          3: v = 2750;
          default: v = 3300;
        endcase
      end
      default: v = $urandom_range(4095, 0);
    endcase
    if (v <= t) v = $urandom_range(4095, t + 1);
    return v;
  endfunction

  task automatic push_mv(input int v);
    sample_queue.push_back(MV_W'(v));
    last_mv = v;
    queued_total++;
  endtask

  // Pilot periods with random shape: rising edge, highs, lows ending below threshold;
  // the rest is noise bursts and rises that just miss the edge condition
  task automatic queue_waveform(input int n_items);
    int t, top, span, highs, stop, low;
    t = int'(cfg_threshold);
    top = (t - 1 < 4094 - t) ? t - 1 : 4094 - t;
    stop = queued_total + n_items;
    while (queued_total < stop) begin
      if (t == 0 || top < 0 || $urandom_range(99) < 15) begin
        repeat ($urandom_range(8, 1)) push_mv($urandom_range(4095, 0));
      end else if ($urandom_range(99) < 10) begin
        if (top >= 1 && $urandom_range(1)) begin
          low = $urandom_range(top, 1);
          push_mv(low);
          push_mv($urandom_range(low + t, t + 1));
        end else begin
          push_mv(t);
          push_mv(4095);
        end
      end else begin
        span = $urandom_range(40, 2);
        highs = ($urandom_range(3) == 0) ? span - 1 : $urandom_range(span - 1, 1);
        if (last_mv > top) push_mv($urandom_range(top, 0));
        push_mv($urandom_range(4095, last_mv + t + 1));
        repeat (highs - 1) push_mv(pick_high_level(t));
        repeat (span - highs - 1) push_mv($urandom_range(t, 0));
        push_mv($urandom_range(top, 0));
      end
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) cfg_threshold = data[MV_W-1:0];
    else if (idx == REG_CAP) cfg_cap = data[CUR_W-1:0];
  endtask

  // Hold off until every request is taken and every reading is back
  task automatic settle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || staged || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] threshold,
                           input logic [CFG_DATA_W-1:0] cap,
                           input int send_pct, input int recv_pct, input int n_items);
    write_register(REG_THRESHOLD, threshold);
    write_register(REG_CAP, cap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_waveform(n_items);
    settle();
  endtask

  // Sample driver: predicts each request as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      pilot_in.valid <= 1'b0;
    end else begin
      if (pilot_in.valid && pilot_in.ready) begin
        expected_readings.push_back(decode_sample(pilot_in.pilot_sample_mv));
        samples_taken++;
        staged = 1'b0;
      end
      if (!staged) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pilot_in.pilot_sample_mv <= sample_queue.pop_front();
          pilot_in.valid <= 1'b1;
          staged = 1'b1;
        end else begin
          pilot_in.valid <= 1'b0;
        end
      end
    end
  end

  // Reading monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst) begin
      if (reading_out.valid && reading_out.ready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] reading with none expected: duty %0d cur %0d class %0d lvl %0d",
                     $realtime, reading_out.duty_percent, reading_out.allowed_current_deciamps,
                     reading_out.pilot_class, reading_out.pilot_level_mv);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (reading_out.duty_percent !== want.duty ||
              reading_out.allowed_current_deciamps !== want.current ||
              reading_out.pilot_class !== want.pilot ||
              reading_out.pilot_level_mv !== want.level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: exp duty %0d cur %0d class %0d lvl %0d, got %0d %0d %0d %0d",
                       $realtime, want.duty, want.current, want.pilot, want.level,
                       reading_out.duty_percent, reading_out.allowed_current_deciamps,
                       reading_out.pilot_class, reading_out.pilot_level_mv);
          end
        end
      end
      reading_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((pilot_in.valid && pilot_in.ready) || (reading_out.valid && reading_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pilot_duty_decoder_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    // Empty period, threshold ties, near-miss rise, then edges onto each class boundary and just inside the windows
    int directed_mv[25] = '{3000, 50, 150, 100, 2750, 0, 3300,
                            0, 2200, 0, 1925, 0, 1375, 0, 2751, 0, 3299,
                            0, 2201, 0, 1924, 0, 4095, 0, 101};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    pilot_in.valid = 1'b0;
    pilot_in.pilot_sample_mv = '0;
    reading_out.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_mv[i]) push_mv(directed_mv[i]);
    queue_waveform(300);
    settle();

    // Writes to unused indexes must change nothing
    write_register(REG_SPARE_A, 12'hABC);
    write_register(REG_SPARE_B, 12'h001);
    run_phase(12'd1000, 12'hFFF, 20, 51, 250);
    send_idle_pct = 51;
    recv_idle_pct = 20;
    run_phase(12'd0, 12'd0, 51, 20, 150);
    run_phase(12'd4095, 12'h5C2, 51, 20, 150);
    run_phase(12'd2000, 12'd300, 51, 20, 250);
    run_phase(12'd1, 12'd900, 0, 0, 300);

    // Long high-heavy period, then long low-heavy period
    write_register(REG_THRESHOLD, 12'd100);
    write_register(REG_CAP, 12'd900);
    push_mv(0);
    repeat (LONG_RUN) push_mv(3000);
    repeat (SHORT_RUN) push_mv(0);
    repeat (SHORT_RUN) push_mv(3000);
    repeat (LONG_RUN) push_mv(0);
    push_mv(3000);
    push_mv(0);
    settle();

    $display("%0d pilot samples over seven threshold/cap settings, incl. skewed periods;",
             samples_taken);
    $display("%0d readings compared, %0d wrong or unexpected.", readings_checked, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("pilot_duty_decoder_tb: PASS");
    end else begin
      $display("pilot_duty_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/pdd_pkg.sv
src/pdd_sample_if.sv
src/pdd_ctrl.sv
src/pdd_dp.sv
src/pilot_duty_decoder.sv
tb/sv/pilot_duty_decoder_tb.sv
